FILE: rtl/core/nfm_pkg.sv
package nfm_pkg;

    localparam int NFM_CHANNELS    = 6;
    localparam int NFM_MAX_CH      = 6;
    localparam logic [3:0] NFM_OPMASK_RST = 4'hf;
    localparam logic [8:0] NFM_KEY_ADDR   = 9'h028;
    localparam logic [8:0] NFM_HI_OFS     = 9'h0a4;
    localparam logic [8:0] NFM_LO_OFS     = 9'h0a0;
    localparam logic [7:0] NFM_NO_NOTE    = 8'hff;
    localparam logic [6:0] NFM_TOP_NOTE   = 7'd120;

    typedef enum logic [1:0] {
        OP_KEY_ON  = 2'd0,
        OP_KEY_OFF = 2'd1,
        OP_MUTE    = 2'd2,
        OP_NONE    = 2'd3
    } nfm_op_t;

    typedef enum logic [1:0] {
        PH_HI  = 2'd0,
        PH_LO  = 2'd1,
        PH_KEY = 2'd2
    } nfm_phase_t;

    typedef enum logic {
        NFM_IDLE = 1'b0,
        NFM_EMIT = 1'b1
    } nfm_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } nfm_cmd_t;

    typedef struct packed {
        logic emit_empty;
        logic last_beat;
        logic out_free;
    } nfm_stat_t;

    function automatic logic [10:0] nfm_pitch(input logic [3:0] semi);
        logic [10:0] p;
        begin
            case (semi)
                4'd0:    p = 11'd617;
                4'd1:    p = 11'd654;
                4'd2:    p = 11'd693;
                4'd3:    p = 11'd734;
                4'd4:    p = 11'd778;
                4'd5:    p = 11'd824;
                4'd6:    p = 11'd873;
                4'd7:    p = 11'd925;
                4'd8:    p = 11'd980;
                4'd9:    p = 11'd1038;
                4'd10:   p = 11'd1100;
                4'd11:   p = 11'd1165;
                default: p = 11'd617;
            endcase
            return p;
        end
    endfunction

    function automatic logic [8:0] nfm_chan_base(input logic [2:0] ch);
        logic [8:0] b;
        begin
            case (ch)
                3'd0:    b = 9'h001;
                3'd1:    b = 9'h002;
                3'd2:    b = 9'h101;
                3'd3:    b = 9'h102;
                3'd4:    b = 9'h000;
                3'd5:    b = 9'h100;
                default: b = 9'h000;
            endcase
            return b;
        end
    endfunction

    function automatic logic [2:0] nfm_key_code(input logic [2:0] ch);
        logic [2:0] k;
        begin
            case (ch)
                3'd0:    k = 3'd0;
                3'd1:    k = 3'd1;
                3'd2:    k = 3'd5;
                3'd3:    k = 3'd6;
                3'd4:    k = 3'd2;
                3'd5:    k = 3'd4;
                default: k = 3'd0;
            endcase
            return k;
        end
    endfunction

endpackage

FILE: rtl/core/nfm_ctrl.sv
module nfm_ctrl
    import nfm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  nfm_stat_t stat,
    output nfm_cmd_t  cmd
);

    nfm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NFM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            NFM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (!stat.emit_empty) begin
                        state_next = NFM_EMIT;
                    end
                end
            end
            NFM_EMIT: begin
                if (stat.out_free) begin
                    cmd.step = 1'b1;
                    if (stat.last_beat) begin
                        state_next = NFM_IDLE;
                    end
                end
            end
            default: state_next = NFM_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/nfm_dpath.sv
module nfm_dpath
    import nfm_pkg::*;
#(
    parameter int CHANNELS = NFM_CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic [15:0] s_tdata,
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    output logic        m_tlast,
    input  logic        m_tready,
    input  nfm_cmd_t    cmd,
    output nfm_stat_t   stat
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [1:0] in_cmd;
    logic [5:0] in_mask;
    logic [6:0] in_note;

    logic [3:0]          opmask_reg;
    logic [7:0]          held_reg [CHANNELS];
    logic [1:0]          cmd_reg;
    logic [6:0]          note_reg;
    logic [3:0]          oct_reg;
    logic [3:0]          semi_reg;
    logic [CHANNELS-1:0] pend_reg;
    nfm_phase_t          phase_reg;

    logic [8:0]  addr_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic        valid_reg;

    logic [CHANNELS-1:0] emit_mask;
    logic [12:0]         oct_prod;
    logic [3:0]          oct_calc;
    logic [6:0]          oct_x12;
    logic [6:0]          semi_calc;

    logic [CH_W-1:0]     cur_ch;
    logic [CHANNELS-1:0] cur_hot;
    logic [CHANNELS-1:0] pend_left;
    logic [2:0]          cur_ch3;
    logic [10:0]         pitch;
    logic [8:0]          beat_addr;
    logic [7:0]          beat_data;

    assign in_cmd  = s_tdata[1:0];
    assign in_mask = s_tdata[7:2];
    assign in_note = s_tdata[14:8];

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            case (in_cmd)
                OP_KEY_ON, OP_MUTE: emit_mask[i] = in_mask[i];
                OP_KEY_OFF:         emit_mask[i] = in_mask[i] &&
                                                   (held_reg[i] == {1'b0, in_note});
                default:            emit_mask[i] = 1'b0;
            endcase
        end
    end

    assign oct_prod  = 13'(in_note) * 13'd43;
    assign oct_calc  = (in_note < NFM_TOP_NOTE) ? oct_prod[12:9] : 4'd0;
    assign oct_x12   = {oct_calc, 3'b000} + {1'b0, oct_calc, 2'b00};
    assign semi_calc = (in_note < NFM_TOP_NOTE) ? (in_note - oct_x12) : 7'd0;

    always_comb begin
        cur_ch  = '0;
        cur_hot = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                cur_ch  = CH_W'(i);
                cur_hot = '0;
                cur_hot[i] = 1'b1;
            end
        end
    end

    assign pend_left = pend_reg & ~cur_hot;
    assign cur_ch3   = 3'(cur_ch);
    assign pitch     = nfm_pitch(semi_reg);

    always_comb begin
        case (phase_reg)
            PH_HI: begin
                beat_addr = nfm_chan_base(cur_ch3) + NFM_HI_OFS;
                beat_data = {1'b0, oct_reg, pitch[10:8]};
            end
            PH_LO: begin
                beat_addr = nfm_chan_base(cur_ch3) + NFM_LO_OFS;
                beat_data = pitch[7:0];
            end
            default: begin
                beat_addr = NFM_KEY_ADDR;
                beat_data = {(cmd_reg == OP_KEY_ON) ? opmask_reg : 4'd0,
                             1'b0, nfm_key_code(cur_ch3)};
            end
        endcase
    end

    assign stat.emit_empty = (emit_mask == '0);
    assign stat.last_beat  = (phase_reg == PH_KEY) && (pend_left == '0);
    assign stat.out_free   = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opmask_reg <= NFM_OPMASK_RST;
            valid_reg  <= 1'b0;
            pend_reg   <= '0;
            phase_reg  <= PH_KEY;
            for (int i = 0; i < CHANNELS; i++) begin
                held_reg[i] <= NFM_NO_NOTE;
            end
        end else begin
            if (cfg_wr_en) begin
                opmask_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                cmd_reg   <= in_cmd;
                note_reg  <= in_note;
                oct_reg   <= oct_calc;
                semi_reg  <= semi_calc[3:0];
                pend_reg  <= emit_mask;
                phase_reg <= (in_cmd == OP_KEY_ON) ? PH_HI : PH_KEY;
            end
            if (cmd.step) begin
                valid_reg <= 1'b1;
                case (phase_reg)
                    PH_HI:   phase_reg <= PH_LO;
                    PH_LO:   phase_reg <= PH_KEY;
                    default: begin
                        pend_reg  <= pend_left;
                        phase_reg <= (cmd_reg == OP_KEY_ON) ? PH_HI : PH_KEY;
                        held_reg[cur_ch] <= (cmd_reg == OP_KEY_ON) ?
                                            {1'b0, note_reg} : NFM_NO_NOTE;
                    end
                endcase
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            addr_reg <= beat_addr;
            data_reg <= beat_data;
            last_reg <= (phase_reg == PH_KEY) && (pend_left == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, data_reg, addr_reg};

endmodule

FILE: rtl/core/note_to_fm_register_writes_unit.sv
// Turns note events into FM chip register writes.
// Input channel s_*: one beat per event (key on, key off, or mute of a
// channel mask). Output channel m_*: one beat per register write, tlast
// on the final write of an event. Config: cfg_wr_en loads the operator
// mask used in key-on data.
// Each selected channel in ascending order gives three writes for key on
// (pitch high, pitch low, key) or one key write for mute, or key off of its held note.
// An event is accepted, then gives its writes (at most 18); an event that
// gives no write leaves the block idle. The channel scan sequencer emits
// one write per cycle while the output is free, which sets the rate.
// The registered event feeds the first write, held in the output register.
// s_tready is high only between events; the next event may be taken
// while the final write still waits in the output register.
// When m_tready is low with a write waiting, the output register holds and the scan stalls.
// Reset clears all held notes to none, the operator mask to all ones,
// and drops any pending writes.
module note_to_fm_register_writes_unit
    import nfm_pkg::*;
#(
    parameter int CHANNELS = NFM_CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[1:0], channel_mask[7:2], note[14:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reg_address[8:0], reg_data[16:9]
    output logic        m_tlast
);

    nfm_cmd_t  cmd;
    nfm_stat_t stat;

    nfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nfm_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tlast     (m_tlast),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .stat        (stat)
    );

    a_no_load_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.step))
        else $error("load and step together");

    a_step_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (!m_tvalid || m_tready))
        else $error("write issued over a waiting beat");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && stat.last_beat) |=> (s_tready && m_tvalid && m_tlast))
        else $error("no return to idle after final write");

    a_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && stat.emit_empty) |=> s_tready)
        else $error("empty event left sequencer busy");

endmodule
